@@ hdl/lec_pkg.sv @@
// ----------------------------------------------------------------------------
// lec_pkg
// Shared types and constants for the LED effect controller: event codes,
// effect modes, config register indexes and the timing constants.
// ----------------------------------------------------------------------------
package lec_pkg;

  typedef logic [2:0] action_t;
  typedef logic [1:0] mode_t;

  // event codes carried in the action field
  localparam action_t ACT_TICK    = 3'd0;
  localparam action_t ACT_ENABLE  = 3'd1;
  localparam action_t ACT_DISABLE = 3'd2;
  localparam action_t ACT_TOGGLE  = 3'd3;
  localparam action_t ACT_NEXT    = 3'd4;

  // effect modes
  localparam mode_t MODE_STEADY = 2'd0;
  localparam mode_t MODE_SLOW   = 2'd1;
  localparam mode_t MODE_FAST   = 2'd2;
  localparam mode_t MODE_BREATH = 2'd3;

  // config register indexes
  localparam logic CFG_BRIGHTNESS = 1'b0;
  localparam logic CFG_POLARITY   = 1'b1;

  // phase arithmetic, all values below the breathing period
  localparam int PHASE_W = 11;
  typedef logic [PHASE_W-1:0] phase_t;

  localparam phase_t BREATH_PERIOD = 11'd2000;
  localparam phase_t BREATH_HALF   = 11'd1000;
  localparam phase_t SLOW_HALF     = 11'd500;
  localparam phase_t FAST_PERIOD   = 11'd250;
  localparam phase_t FAST_HALF     = 11'd125;
  localparam phase_t BREATH_PWM    = 11'd20;
  localparam logic [4:0] BRIGHT_PWM = 5'd10;
  localparam logic [6:0] FULL_LEVEL = 7'd100;

  // breathing period is 16 * 125: odd factor and its reciprocal,
  // x/125 = (x*RECIP_125)>>35 for any x below 2^28
  localparam logic [6:0]  PERIOD_ODD = 7'd125;
  localparam logic [28:0] RECIP_125  = 29'd274877907;

  // reciprocal constants: x/50 = (x*1311)>>16, y/100 = (y*1311)>>17,
  // b/10 = (b*205)>>11, n/5 = (n*205)>>10 over the value ranges used here
  localparam logic [10:0] RECIP_50_100 = 11'd1311;
  localparam logic [7:0]  RECIP_10     = 8'd205;

endpackage

@@ hdl/led_effect_controller.sv @@
// ----------------------------------------------------------------------------
// led_effect_controller
// Single LED driver with steady, slow blink, fast blink and breathing
// effects, brightness PWM and selectable pin polarity.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | action, tick_ms
// out     | output    | out_valid / out_ready| led_on, pin_level
// cfg     | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// A tick while powered runs six steps through one shared 29 x 29 multiplier:
// quotient by 125, time modulo 2000, modulo 20, breathing duty, brightness
// scaling and the final compare. Its result is registered in the final step,
// and the next beat enters only once the sequencer is back in idle, so no
// beat is taken while a tick is in flight. Any other beat has its result
// registered at acceptance. Ticks are taken modulo 2^min(TICK_BITS, 32).
// Reset is synchronous: power off, steady mode, LED dark, brightness 100,
// active-low pin. A result waits in the output register until taken; a new
// beat is taken only when that register is free or being emptied.
// ----------------------------------------------------------------------------
module led_effect_controller #(
  parameter int TICK_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [31:0] tick_ms,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic        led_on,
  output logic        pin_level
);

  localparam int TW = (TICK_BITS < 32) ? TICK_BITS : 32;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QUOT  = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_MOD20 = 3'd3;
  localparam logic [2:0] S_DUTY  = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_FINAL = 3'd6;

  logic [2:0]             state;
  logic [6:0]             brightness_level;
  logic                   active_low_pin;
  logic                   power_enabled;
  lec_pkg::mode_t         effect_mode;
  logic                   led_lit;

  logic [TW-1:0]          tval;
  logic [21:0]            quot;
  lec_pkg::phase_t        phase;
  logic [4:0]             r20;
  logic [4:0]             duty;
  logic [11:0]            sprod;

  logic                   in_beat;
  logic                   power_next;
  lec_pkg::mode_t         mode_next;
  logic                   lit_next;
  logic                   start_tick;

  // input side free when idle and the result slot is empty or draining
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_beat  = in_valid && in_ready;

  // event decode for everything that finishes at acceptance
  always_comb begin
    power_next = power_enabled;
    mode_next  = effect_mode;
    lit_next   = led_lit;
    start_tick = 1'b0;
    case (lec_pkg::action_t'(action))
      lec_pkg::ACT_TICK: begin
        start_tick = power_enabled;
      end
      lec_pkg::ACT_ENABLE: begin
        power_next = 1'b1;
      end
      lec_pkg::ACT_DISABLE: begin
        power_next = 1'b0;
        lit_next   = 1'b0;
      end
      lec_pkg::ACT_TOGGLE: begin
        power_next = !power_enabled;
        if (power_enabled) begin
          lit_next = 1'b0;
        end
      end
      lec_pkg::ACT_NEXT: begin
        if (power_enabled) begin
          mode_next = effect_mode + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // breathing triangle
  lec_pkg::phase_t  tri_x;

  assign tri_x = (phase < lec_pkg::BREATH_HALF) ? phase : (lec_pkg::BREATH_PERIOD - phase);

  // shared multiplier, operands picked by the sequencer step
  logic [28:0]      mul_a;
  logic [28:0]      mul_b;
  logic [57:0]      mprod;
  logic [27:0]      xq;

  assign xq = 28'(tval >> 4);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_QUOT: begin
        mul_a = 29'(xq);
        mul_b = lec_pkg::RECIP_125;
      end
      S_REM: begin
        mul_a = 29'(quot);
        mul_b = 29'(lec_pkg::PERIOD_ODD);
      end
      S_MOD20: begin
        mul_a = 29'(phase[10:2]);
        mul_b = 29'(lec_pkg::RECIP_10);
      end
      S_DUTY: begin
        mul_a = 29'(tri_x);
        mul_b = 29'(lec_pkg::RECIP_50_100);
      end
      S_SCALE: begin
        mul_a = 29'(duty);
        mul_b = 29'(brightness_level);
      end
      S_FINAL: begin
        mul_a = 29'(sprod);
        mul_b = 29'(lec_pkg::RECIP_50_100);
      end
      default: begin
      end
    endcase
  end

  assign mprod = 58'(mul_a) * 58'(mul_b);

  // remainder by 125 and by 20 from the quotients
  logic [27:0]      rem;
  logic [10:0]      q20;
  logic [10:0]      diff20;

  assign rem    = xq - mprod[27:0];
  assign q20    = {mprod[16:10], 4'b0000} + {2'b00, mprod[16:10], 2'b00};
  assign diff20 = phase - q20;

  // final evaluation of the selected effect
  logic [4:0]       scaled;
  logic [14:0]      tprod;
  logic [3:0]       tenth;
  logic [4:0]       r10;
  lec_pkg::phase_t  p1000;
  lec_pkg::phase_t  p500;
  lec_pkg::phase_t  p250;
  logic             want_on;
  logic             eval_lit;

  assign scaled = mprod[21:17];
  assign tprod  = 15'(brightness_level) * 15'(lec_pkg::RECIP_10);
  assign tenth  = tprod[14:11];
  assign r10    = (r20 >= lec_pkg::BRIGHT_PWM) ? (r20 - lec_pkg::BRIGHT_PWM) : r20;
  assign p1000  = (phase >= lec_pkg::BREATH_HALF) ? (phase - lec_pkg::BREATH_HALF) : phase;
  assign p500   = (p1000 >= lec_pkg::SLOW_HALF) ? (p1000 - lec_pkg::SLOW_HALF) : p1000;
  assign p250   = (p500 >= lec_pkg::FAST_PERIOD) ? (p500 - lec_pkg::FAST_PERIOD) : p500;

  always_comb begin
    case (effect_mode)
      lec_pkg::MODE_SLOW: want_on = (p1000 < lec_pkg::SLOW_HALF);
      lec_pkg::MODE_FAST: want_on = (p250 < lec_pkg::FAST_HALF);
      default:            want_on = 1'b1;
    endcase
    if (effect_mode == lec_pkg::MODE_BREATH) begin
      eval_lit = (r20 < scaled);
    end else begin
      eval_lit = want_on && (r10 < {1'b0, tenth});
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness_level <= lec_pkg::FULL_LEVEL;
      active_low_pin   <= 1'b1;
    end else if (cfg_wr_en) begin
      if (cfg_index == lec_pkg::CFG_BRIGHTNESS) begin
        brightness_level <= (cfg_wdata > lec_pkg::FULL_LEVEL) ? lec_pkg::FULL_LEVEL : cfg_wdata;
      end else begin
        active_low_pin <= cfg_wdata[0];
      end
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      power_enabled <= 1'b0;
      effect_mode   <= lec_pkg::MODE_STEADY;
      led_lit       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // result slot fills on a finished beat, empties when taken
      if ((in_beat && !start_tick) || (state == S_FINAL)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            power_enabled <= power_next;
            effect_mode   <= mode_next;
            led_lit       <= lit_next;
            if (start_tick) begin
              state <= S_QUOT;
            end
          end
        end
        S_QUOT: begin
          state <= S_REM;
        end
        S_REM: begin
          state <= S_MOD20;
        end
        S_MOD20: begin
          state <= S_DUTY;
        end
        S_DUTY: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          state <= S_FINAL;
        end
        S_FINAL: begin
          led_lit <= eval_lit;
          state   <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        tval <= tick_ms[TW-1:0];
        if (in_beat) begin
          led_on    <= lit_next;
          pin_level <= lit_next ^ active_low_pin;
        end
      end
      S_QUOT: begin
        quot <= mprod[56:35];
      end
      S_REM: begin
        phase <= {rem[6:0], tval[3:0]};
      end
      S_MOD20: begin
        r20 <= diff20[4:0];
      end
      S_DUTY: begin
        duty <= mprod[20:16];
      end
      S_SCALE: begin
        sprod <= mprod[11:0];
      end
      S_FINAL: begin
        led_on    <= eval_lit;
        pin_level <= eval_lit ^ active_low_pin;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/lec_checker.sv @@
// ----------------------------------------------------------------------------
// lec_checker
// Port-level checks for the LED effect controller, bound to the top level.
// ----------------------------------------------------------------------------
module lec_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] action,
  input logic       out_valid,
  input logic       out_ready,
  input logic       led_on,
  input logic       pin_level
);

  // a waiting result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led_on) && $stable(pin_level))
    else $error("result beat changed while stalled");

  // disable darkens the led in the very next result
  a_disable_dark: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (action == lec_pkg::ACT_DISABLE) |=> out_valid && !led_on)
    else $error("disable did not report a dark led");

  // no new beat while an untaken result would be overwritten
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_ready)
    else $error("input ready while result slot is blocked");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind led_effect_controller lec_checker u_lec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .action    (action),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .led_on    (led_on),
  .pin_level (pin_level)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LED effect controller. Event and tick beats are
// fed through a bursty valid/ready driver, results are taken by a stalling
// receiver, and every result is checked against an in-bench LED predictor
// across several brightness and polarity settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // predictor constants: times in milliseconds, breathing steps and full percent
  localparam longint unsigned SLOW_HALF_MS = 500;
  localparam longint unsigned FAST_HALF_MS = 125;
  localparam longint unsigned BREATH_MS    = 2000;
  localparam longint unsigned BREATH_STEPS = 20;
  localparam longint unsigned DIM_PWM_MS   = 10;
  localparam longint unsigned FULL_PCT     = 100;

  localparam int RANDOM_PHASES  = 10;
  localparam int BEATS_PER_PHASE = 155;
  localparam int HOLD_CYCLES    = 500;
  localparam int HOLD_AFTER     = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    lec_pkg::action_t act;
    logic [31:0]      t;
  } led_beat_t;

  typedef struct packed {
    logic on;
    logic pin;
  } led_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_index = lec_pkg::CFG_BRIGHTNESS;
  logic [6:0]       cfg_wdata = 7'd0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  lec_pkg::action_t action = lec_pkg::ACT_TICK;
  logic [31:0]      tick_ms = 32'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             led_on;
  logic             pin_level;

  led_effect_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .tick_ms   (tick_ms),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led_on    (led_on),
    .pin_level (pin_level)
  );

  // beats waiting to be driven, results waiting to arrive
  led_beat_t   pending_beats[$];
  led_result_t expected_leds[$];

  // predicted controller state
  logic           pwr_on = 1'b0;
  lec_pkg::mode_t fx_mode = lec_pkg::MODE_STEADY;
  logic           lit_now = 1'b0;
  logic [6:0]     bright_pct = 7'd100;
  logic           pin_active_low = 1'b1;

  // bookkeeping
  int unsigned beats_in = 0;
  int unsigned results_seen = 0;
  int unsigned lit_results = 0;
  int unsigned mismatches = 0;
  int unsigned mode_ticks[4] = '{0, 0, 0, 0};

  // handshake and idling state
  logic        beat_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  logic [7:0]  stall_pat = 8'hFF;
  logic [7:0]  pat_age = 8'd0;

  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #8_000_000;
    $display("led_effect_controller: mismatch");
    $finish;
  end

  // LED level that a tick at time t produces while powered
  function automatic logic lit_at(lec_pkg::mode_t m, logic [6:0] pct, logic [31:0] t);
    longint unsigned tt, phase, duty;
    logic want;
    tt = t;
    want = 1'b1;
    case (m)
      lec_pkg::MODE_BREATH: begin
        phase = tt % BREATH_MS;
        duty = (phase < BREATH_MS / 2) ? phase * BREATH_STEPS / (BREATH_MS / 2)
                                       : (BREATH_MS - phase) * BREATH_STEPS / (BREATH_MS / 2);
        return (tt % BREATH_STEPS) < duty * pct / FULL_PCT;
      end
      lec_pkg::MODE_SLOW: want = (tt % (2 * SLOW_HALF_MS)) < SLOW_HALF_MS;
      lec_pkg::MODE_FAST: want = (tt % (2 * FAST_HALF_MS)) < FAST_HALF_MS;
      default: want = 1'b1;
    endcase
    // brightness pwm gates the on phase
    if (!want || pct == 0) return 1'b0;
    if (pct >= FULL_PCT) return 1'b1;
    return (tt % DIM_PWM_MS) < pct * DIM_PWM_MS / FULL_PCT;
  endfunction

  // apply one beat to the predicted state and return the LED result
  function automatic led_result_t advance_led(led_beat_t b);
    led_result_t r;
    case (b.act)
      lec_pkg::ACT_TICK: begin
        if (pwr_on) begin
          mode_ticks[fx_mode]++;
          lit_now = lit_at(fx_mode, bright_pct, b.t);
        end
      end
      lec_pkg::ACT_ENABLE: pwr_on = 1'b1;
      lec_pkg::ACT_DISABLE: begin
        pwr_on = 1'b0;
        lit_now = 1'b0;
      end
      lec_pkg::ACT_TOGGLE: begin
        if (pwr_on) begin
          pwr_on = 1'b0;
          lit_now = 1'b0;
        end else begin
          pwr_on = 1'b1;
        end
      end
      lec_pkg::ACT_NEXT: begin
        if (pwr_on) fx_mode = lec_pkg::mode_t'(fx_mode + 2'd1);
      end
      default: ;
    endcase
    r.on = lit_now;
    r.pin = lit_now ^ pin_active_low;
    return r;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: %s expected %b got %b", results_seen, name, want, got);
    end
  endfunction

  // monitor: config tracking, expectation on each input beat, check on each result
  always @(posedge clk) begin
    led_result_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= in_valid && in_ready;
      if (cfg_wr_en) begin
        if (cfg_index == lec_pkg::CFG_BRIGHTNESS)
          bright_pct = (cfg_wdata > lec_pkg::FULL_LEVEL) ? lec_pkg::FULL_LEVEL : cfg_wdata;
        else
          pin_active_low = cfg_wdata[0];
      end
      if (out_valid && out_ready) begin
        if (expected_leds.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: no result expected, got led_on %b pin_level %b",
                     results_seen, led_on, pin_level);
        end else begin
          want = expected_leds.pop_front();
          check_field("led_on", want.on, led_on);
          check_field("pin_level", want.pin, pin_level);
          if (want.on) lit_results++;
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        expected_leds.push_back(advance_led('{act: action, t: tick_ms}));
        beats_in++;
      end
    end
  end

  // driver: bursts of beats with random gaps, payload held until taken
  always @(negedge clk) begin
    led_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        nb = pending_beats.pop_front();
        in_valid <= 1'b1;
        action <= nb.act;
        tick_ms <= nb.t;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                   : $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (pat_age == 8'd0)
        stall_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      out_ready <= stall_pat[pat_age[2:0]];
      pat_age <= pat_age + 8'd1;
    end
  end

  task automatic queue_beat(lec_pkg::action_t a, logic [31:0] t);
    pending_beats.push_back('{act: a, t: t});
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_leds.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // one powered session: time mostly marching forward, events mixed in
  task automatic plan_traffic(int unsigned count);
    int unsigned k, pick;
    logic [31:0] now;
    now = $urandom;
    queue_beat(lec_pkg::ACT_ENABLE, $urandom);
    for (k = 1; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        if ($urandom_range(0, 29) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 300);
        else if ($urandom_range(0, 19) == 0) now = $urandom;
        else now = now + $urandom_range(1, 97);
        queue_beat(lec_pkg::ACT_TICK, now);
      end else if (pick < 80) queue_beat(lec_pkg::ACT_NEXT, $urandom);
      else if (pick < 85) queue_beat(lec_pkg::ACT_ENABLE, $urandom);
      else if (pick < 89) queue_beat(lec_pkg::ACT_DISABLE, $urandom);
      else if (pick < 95) queue_beat(lec_pkg::ACT_TOGGLE, $urandom);
      else queue_beat(lec_pkg::action_t'(lec_pkg::ACT_NEXT +
                                         lec_pkg::action_t'($urandom_range(1, 3))), $urandom);
    end
  endtask

  // stimulus sequence
  initial begin
    logic [6:0] pct_list[RANDOM_PHASES];
    int unsigned p;
    pct_list = '{7'd0, 7'd127, 7'd1, 7'd99, 7'd100, 7'd101, 7'd50, 7'd10, 7'd0, 7'd0};
    pct_list[8] = 7'($urandom_range(0, 127));
    pct_list[9] = 7'($urandom_range(0, 100));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_cfg(lec_pkg::CFG_BRIGHTNESS, 7'd100);
    write_cfg(lec_pkg::CFG_POLARITY, 7'd1);

    // directed: events while off, every mode with its edges, unknown codes
    @(posedge clk);
    queue_beat(lec_pkg::ACT_TICK, 32'd0);
    queue_beat(lec_pkg::ACT_NEXT, 32'hFFFF_FFFF);
    queue_beat(lec_pkg::ACT_ENABLE, 32'd0);
    queue_beat(lec_pkg::ACT_TICK, 32'hFFFF_FFFF);
    queue_beat(lec_pkg::action_t'(lec_pkg::ACT_NEXT + 3'd1), 32'd0);
    queue_beat(lec_pkg::action_t'(lec_pkg::ACT_NEXT + 3'd2), 32'hFFFF_FFFF);
    queue_beat(lec_pkg::action_t'(lec_pkg::ACT_NEXT + 3'd3), 32'h5555_AAAA);
    queue_beat(lec_pkg::ACT_NEXT, 32'd0);
    queue_beat(lec_pkg::ACT_TICK, 32'd499);
    queue_beat(lec_pkg::ACT_TICK, 32'd500);
    queue_beat(lec_pkg::ACT_NEXT, 32'd0);
    queue_beat(lec_pkg::ACT_TICK, 32'd124);
    queue_beat(lec_pkg::ACT_TICK, 32'd125);
    queue_beat(lec_pkg::ACT_NEXT, 32'd0);
    queue_beat(lec_pkg::ACT_TICK, 32'd1000);
    queue_beat(lec_pkg::ACT_TICK, 32'd0);
    queue_beat(lec_pkg::ACT_TICK, 32'd1999);
    queue_beat(lec_pkg::ACT_NEXT, 32'd0);
    queue_beat(lec_pkg::ACT_TOGGLE, 32'd0);
    queue_beat(lec_pkg::ACT_TICK, 32'd7);
    queue_beat(lec_pkg::ACT_TOGGLE, 32'hAAAA_5555);
    queue_beat(lec_pkg::ACT_TICK, 32'd5);
    queue_beat(lec_pkg::ACT_DISABLE, 32'd0);
    queue_beat(lec_pkg::ACT_TICK, 32'd3);
    wait_idle();

    // random phases over brightness extremes and both polarities
    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_cfg(lec_pkg::CFG_BRIGHTNESS, pct_list[p]);
      write_cfg(lec_pkg::CFG_POLARITY, 7'(p & 1));
      @(posedge clk);
      plan_traffic(BEATS_PER_PHASE);
      wait_idle();
    end

    repeat (60) @(negedge clk);
    $display("covered %0d beats and %0d results, %0d of them lit", beats_in, results_seen,
             lit_results);
    $display("powered ticks steady %0d, slow %0d, fast %0d, breathing %0d",
             mode_ticks[lec_pkg::MODE_STEADY], mode_ticks[lec_pkg::MODE_SLOW],
             mode_ticks[lec_pkg::MODE_FAST], mode_ticks[lec_pkg::MODE_BREATH]);
    if (expected_leds.size() != 0)
      $display("%0d results never arrived", expected_leds.size());
    if (mismatches == 0 && expected_leds.size() == 0) begin
      $display("led_effect_controller: match");
    end else begin
      $display("led_effect_controller: mismatch");
    end
    $finish;
  end

endmodule
